[src/nrm_pkg.sv]
// ----------------------------------------------------------------------------
// nrm_pkg: shared types and codes for the node run mode controller
// Mode encoding, item kinds, command and error codes, item and result types.
// ----------------------------------------------------------------------------
package nrm_pkg;

    localparam int ID_W         = 16;
    localparam int ID_BITS_DEF  = 16;
    localparam int TAG_W        = 16;
    localparam int KIND_W       = 2;
    localparam int CODE_W       = 4;
    localparam int ERR_W        = 3;
    localparam int MODE_W       = 3;

    typedef enum logic [4:0] {
        ST_STOPPED    = 5'b00001,
        ST_RUNNING    = 5'b00010,
        ST_ESTOP      = 5'b00100,
        ST_RECOVERING = 5'b01000,
        ST_ERROR      = 5'b10000
    } mode_t;

    localparam logic [MODE_W-1:0] MODE_STOPPED    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RUNNING    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ESTOP      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RECOVERING = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERROR      = 3'd4;

    localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAMERA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd2;

    localparam logic [CODE_W-1:0] CMD_START    = 4'd0;
    localparam logic [CODE_W-1:0] CMD_RESTART  = 4'd1;
    localparam logic [CODE_W-1:0] CMD_STOP     = 4'd2;
    localparam logic [CODE_W-1:0] CMD_ESTOP    = 4'd3;
    localparam logic [CODE_W-1:0] CMD_RECOVERY = 4'd4;
    localparam logic [CODE_W-1:0] CMD_INIT     = 4'd5;
    localparam logic [CODE_W-1:0] CMD_STATUS   = 4'd6;

    localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_TARGET      = 3'd1;
    localparam logic [ERR_W-1:0] ERR_STATE       = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CAMERA      = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 3'd4;

    typedef struct packed {
        mode_t mode;
        logic  camera_ok;
        logic  reset_pending;
    } ctl_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] cmd;
        logic [CODE_W-1:0] command_code;
        logic [ID_W-1:0]   target_id;
        logic              target_broadcast;
        logic [TAG_W-1:0]  request_tag;
        logic              camera_up;
    } item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  request_echo;
        logic              rejected;
        logic [ERR_W-1:0]  error_kind;
        logic              flush_work;
        logic [MODE_W-1:0] mode_now;
        logic              processing_on;
        logic              reset_was_pending;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] c;
        c = MODE_STOPPED;
        unique case (m)
            ST_STOPPED:    c = MODE_STOPPED;
            ST_RUNNING:    c = MODE_RUNNING;
            ST_ESTOP:      c = MODE_ESTOP;
            ST_RECOVERING: c = MODE_RECOVERING;
            ST_ERROR:      c = MODE_ERROR;
            default:       c = MODE_STOPPED;
        endcase
        return c;
    endfunction

endpackage

[src/nrm_step.sv]
// ----------------------------------------------------------------------------
// nrm_step: mode transition logic
// Computes the next controller state and the result for one item.
// ----------------------------------------------------------------------------
module nrm_step
    import nrm_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  ctl_state_t                                  cur,
    input  item_t                                       item,
    input  logic [((ID_BITS < ID_W) ? ID_BITS : ID_W)-1:0] node_id,
    output ctl_state_t                                  nxt,
    output result_t                                     res
);

    localparam int CMP_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    logic             hit;
    logic             rej;
    logic [ERR_W-1:0] err;
    logic             clr;
    logic             was;

    assign hit = item.target_broadcast || (item.target_id[CMP_BITS-1:0] == node_id);

    always_comb
    begin
        nxt = cur;
        rej = 1'b0;
        err = ERR_NONE;
        clr = 1'b0;
        was = 1'b0;
        unique case (item.cmd) inside
            KIND_COMMAND:
            begin
                if (!hit)
                begin
                    rej = 1'b1;
                    err = ERR_TARGET;
                end
                else
                begin
                    unique case (item.command_code) inside
                        CMD_START, CMD_RESTART:
                        begin
                            if (cur.mode == ST_RUNNING)
                            begin
                            end
                            else if (cur.mode != ST_STOPPED)
                            begin
                                rej = 1'b1;
                                err = ERR_STATE;
                            end
                            else if (!cur.camera_ok)
                            begin
                                rej = 1'b1;
                                err = ERR_CAMERA;
                            end
                            else
                            begin
                                nxt.mode = ST_RUNNING;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (cur.mode == ST_STOPPED)
                            begin
                            end
                            else if (cur.mode != ST_RUNNING)
                            begin
                                rej = 1'b1;
                                err = ERR_STATE;
                            end
                            else
                            begin
                                nxt.mode = ST_STOPPED;
                                clr      = 1'b1;
                            end
                        end
                        CMD_ESTOP:
                        begin
                            nxt.mode = ST_ESTOP;
                            clr      = 1'b1;
                        end
                        CMD_RECOVERY:
                        begin
                            if (cur.mode == ST_RECOVERING)
                            begin
                            end
                            else if (cur.mode != ST_ESTOP && cur.mode != ST_ERROR)
                            begin
                                rej = 1'b1;
                                err = ERR_STATE;
                            end
                            else
                            begin
                                nxt.mode          = ST_RECOVERING;
                                nxt.camera_ok     = 1'b0;
                                nxt.reset_pending = 1'b1;
                                clr               = 1'b1;
                            end
                        end
                        CMD_INIT:
                        begin
                            if (cur.mode == ST_STOPPED)
                            begin
                            end
                            else if (cur.mode != ST_RECOVERING)
                            begin
                                rej = 1'b1;
                                err = ERR_STATE;
                            end
                            else if (!cur.camera_ok)
                            begin
                                rej = 1'b1;
                                err = ERR_CAMERA;
                            end
                            else
                            begin
                                nxt.mode = ST_STOPPED;
                                clr      = 1'b1;
                            end
                        end
                        CMD_STATUS:
                        begin
                        end
                        default:
                        begin
                            rej = 1'b1;
                            err = ERR_UNSUPPORTED;
                        end
                    endcase
                end
            end
            KIND_CAMERA:
            begin
                nxt.camera_ok = item.camera_up;
                if (!item.camera_up && cur.mode == ST_RUNNING)
                begin
                    nxt.mode = ST_ERROR;
                end
            end
            KIND_CONSUME:
            begin
                was               = cur.reset_pending;
                nxt.reset_pending = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.request_echo      = item.request_tag;
        res.rejected          = rej;
        res.error_kind        = err;
        res.flush_work        = clr;
        res.mode_now          = mode_code(nxt.mode);
        res.processing_on     = (nxt.mode == ST_RUNNING) && nxt.camera_ok;
        res.reset_was_pending = was;
    end

endmodule

[src/node_run_mode_controller.sv]
// ----------------------------------------------------------------------------
// node_run_mode_controller: operating-mode controller for a processing node
// Input register, transition logic against the mode state, result register.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | cmd, command_code, target_id,
//           |                      | target_broadcast, request_tag, camera_up
//   out     | out_valid/ out_ready | request_echo, rejected, error_kind,
//           |                      | flush_work, mode_now, processing_on,
//           |                      | reset_was_pending
//   cfg     | cfg_valid/ cfg_ready | cfg_data (node_id)
//
// One item per cycle while the result is not stalled; results are registered.
// The state updates when an item moves from the input register to the
// result register. Reset: stopped, camera down, no reset request, node_id 0.
// A stalled result holds the input register; in_ready drops once both fill.
// ----------------------------------------------------------------------------
module node_run_mode_controller
    import nrm_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ID_W-1:0]   cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] cmd,
    input  logic [CODE_W-1:0] command_code,
    input  logic [ID_W-1:0]   target_id,
    input  logic              target_broadcast,
    input  logic [TAG_W-1:0]  request_tag,
    input  logic              camera_up,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TAG_W-1:0]  request_echo,
    output logic              rejected,
    output logic [ERR_W-1:0]  error_kind,
    output logic              flush_work,
    output logic [MODE_W-1:0] mode_now,
    output logic              processing_on,
    output logic              reset_was_pending
);

    localparam int CMP_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    logic [CMP_BITS-1:0] node_id_reg;
    ctl_state_t          state_reg;
    ctl_state_t          state_next;
    logic                hold_valid_reg;
    item_t               hold_reg;
    logic                res_valid_reg;
    result_t             res_reg;
    result_t             res_next;
    logic                advance;

    assign cfg_ready = 1'b1;
    assign advance   = hold_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_id_reg <= cfg_data[CMP_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_reg.cmd              <= cmd;
            hold_reg.command_code     <= command_code;
            hold_reg.target_id        <= target_id;
            hold_reg.target_broadcast <= target_broadcast;
            hold_reg.request_tag      <= request_tag;
            hold_reg.camera_up        <= camera_up;
        end
    end

    nrm_step #(
        .ID_BITS (ID_BITS)
    ) u_step (
        .cur     (state_reg),
        .item    (hold_reg),
        .node_id (node_id_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= ST_STOPPED;
            state_reg.camera_ok     <= 1'b0;
            state_reg.reset_pending <= 1'b0;
            res_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = res_valid_reg;
    assign request_echo      = res_reg.request_echo;
    assign rejected          = res_reg.rejected;
    assign error_kind        = res_reg.error_kind;
    assign flush_work        = res_reg.flush_work;
    assign mode_now          = res_reg.mode_now;
    assign processing_on     = res_reg.processing_on;
    assign reset_was_pending = res_reg.reset_was_pending;

    a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.mode))
        else $error("mode state not one-hot");

    a_reject_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rejected == (error_kind != ERR_NONE)))
        else $error("rejected flag and error kind disagree");

    a_proc_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && processing_on) |-> (mode_now == MODE_RUNNING))
        else $error("processing enabled outside running mode");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (hold_valid_reg && res_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

endmodule

[tb/node_run_mode_controller_tb.sv]
// ----------------------------------------------------------------------------
// node_run_mode_controller_tb: self-checking bench for the run mode controller
// A directed table walks reset, target matching, unsupported codes and the
// main mode transitions. Random phases follow, each under its own node ID.
// Every accepted item is run through a local model of the mode logic, and
// each result is checked field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module node_run_mode_controller_tb;
    import nrm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam logic [CODE_W-1:0] CMD_DEST     = 4'd7;
    localparam logic [CODE_W-1:0] CMD_UNKNOWN  = 4'd8;
    localparam logic [CODE_W-1:0] CMD_CODE_TOP = 4'd15;

    localparam int DIR_ROWS       = 25;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int PHASES         = 5;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        item_t   stim;
        logic    fixed;
        result_t want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ID_W-1:0]   cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [KIND_W-1:0] cmd;
    logic [CODE_W-1:0] command_code;
    logic [ID_W-1:0]   target_id;
    logic              target_broadcast;
    logic [TAG_W-1:0]  request_tag;
    logic              camera_up;
    logic              out_valid;
    logic              out_ready;
    logic [TAG_W-1:0]  request_echo;
    logic              rejected;
    logic [ERR_W-1:0]  error_kind;
    logic              flush_work;
    logic [MODE_W-1:0] mode_now;
    logic              processing_on;
    logic              reset_was_pending;

    // model state
    logic [ID_W-1:0]   node_id_q;
    logic [MODE_W-1:0] ctl_mode;
    logic              cam_ok;
    logic              reset_req;

    result_t  awaited_replies[$];
    dir_row_t dir_rows [DIR_ROWS];
    int       mismatches;
    int       quiet_cycles;
    bit       tx_idle_on;
    bit       rx_idle_on;

    node_run_mode_controller dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .command_code      (command_code),
        .target_id         (target_id),
        .target_broadcast  (target_broadcast),
        .request_tag       (request_tag),
        .camera_up         (camera_up),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .request_echo      (request_echo),
        .rejected          (rejected),
        .error_kind        (error_kind),
        .flush_work        (flush_work),
        .mode_now          (mode_now),
        .processing_on     (processing_on),
        .reset_was_pending (reset_was_pending)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Applies one item to the model state and returns the reply it causes.
    function automatic result_t step_controller(input item_t it);
        result_t r;
        r = '0;
        r.request_echo = it.request_tag;
        if (it.cmd == KIND_COMMAND)
        begin
            if (!it.target_broadcast && it.target_id != node_id_q)
            begin
                r.rejected   = 1'b1;
                r.error_kind = ERR_TARGET;
            end
            else
            begin
                case (it.command_code)
                    CMD_START, CMD_RESTART:
                    begin
                        if (ctl_mode != MODE_RUNNING)
                        begin
                            if (ctl_mode != MODE_STOPPED)
                            begin
                                r.rejected   = 1'b1;
                                r.error_kind = ERR_STATE;
                            end
                            else if (!cam_ok)
                            begin
                                r.rejected   = 1'b1;
                                r.error_kind = ERR_CAMERA;
                            end
                            else
                                ctl_mode = MODE_RUNNING;
                        end
                    end
                    CMD_STOP:
                    begin
                        if (ctl_mode == MODE_RUNNING)
                        begin
                            ctl_mode     = MODE_STOPPED;
                            r.flush_work = 1'b1;
                        end
                        else if (ctl_mode != MODE_STOPPED)
                        begin
                            r.rejected   = 1'b1;
                            r.error_kind = ERR_STATE;
                        end
                    end
                    CMD_ESTOP:
                    begin
                        ctl_mode     = MODE_ESTOP;
                        r.flush_work = 1'b1;
                    end
                    CMD_RECOVERY:
                    begin
                        if (ctl_mode == MODE_ESTOP || ctl_mode == MODE_ERROR)
                        begin
                            ctl_mode     = MODE_RECOVERING;
                            cam_ok       = 1'b0;
                            reset_req    = 1'b1;
                            r.flush_work = 1'b1;
                        end
                        else if (ctl_mode != MODE_RECOVERING)
                        begin
                            r.rejected   = 1'b1;
                            r.error_kind = ERR_STATE;
                        end
                    end
                    CMD_INIT:
                    begin
                        if (ctl_mode == MODE_RECOVERING && cam_ok)
                        begin
                            ctl_mode     = MODE_STOPPED;
                            r.flush_work = 1'b1;
                        end
                        else if (ctl_mode == MODE_RECOVERING)
                        begin
                            r.rejected   = 1'b1;
                            r.error_kind = ERR_CAMERA;
                        end
                        else if (ctl_mode != MODE_STOPPED)
                        begin
                            r.rejected   = 1'b1;
                            r.error_kind = ERR_STATE;
                        end
                    end
                    CMD_STATUS:
                        r.rejected = 1'b0;
                    default:
                    begin
                        r.rejected   = 1'b1;
                        r.error_kind = ERR_UNSUPPORTED;
                    end
                endcase
            end
        end
        else if (it.cmd == KIND_CAMERA)
        begin
            cam_ok = it.camera_up;
            if (!it.camera_up && ctl_mode == MODE_RUNNING)
                ctl_mode = MODE_ERROR;
        end
        else if (it.cmd == KIND_CONSUME)
        begin
            r.reset_was_pending = reset_req;
            reset_req           = 1'b0;
        end
        r.mode_now      = ctl_mode;
        r.processing_on = (ctl_mode == MODE_RUNNING) && cam_ok;
        return r;
    endfunction

    // Mostly a plausible next step for the current mode, else noise.
    function automatic item_t draw_item();
        item_t pick;
        int    roll;
        pick.cmd              = KIND_W'($urandom_range(0, 3));
        pick.command_code     = CODE_W'($urandom_range(0, 15));
        pick.target_id        = ID_W'($urandom_range(0, 16'hFFFF));
        pick.target_broadcast = 1'($urandom_range(0, 1));
        pick.request_tag      = TAG_W'($urandom_range(0, 16'hFFFF));
        pick.camera_up        = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            pick.cmd          = KIND_COMMAND;
            pick.command_code = CODE_W'($urandom_range(0, 8));
            if (!pick.target_broadcast)
                pick.target_id = node_id_q;
        end
        if (roll < 65)
        begin
            roll = $urandom_range(0, 3);
            case (ctl_mode)
                MODE_STOPPED:
                begin
                    if (!cam_ok)
                    begin
                        pick.cmd       = KIND_CAMERA;
                        pick.camera_up = 1'b1;
                    end
                    else if (roll == 0)
                        pick.command_code = CMD_START;
                    else if (roll == 1)
                        pick.command_code = CMD_RESTART;
                    else if (roll == 2)
                        pick.command_code = CMD_STATUS;
                    else
                        pick.command_code = CMD_ESTOP;
                end
                MODE_RUNNING:
                begin
                    if (roll == 0)
                        pick.command_code = CMD_STOP;
                    else if (roll == 1)
                        pick.command_code = CMD_ESTOP;
                    else if (roll == 2)
                    begin
                        pick.cmd       = KIND_CAMERA;
                        pick.camera_up = 1'b0;
                    end
                    else
                        pick.command_code = CMD_STATUS;
                end
                MODE_RECOVERING:
                begin
                    if (reset_req && roll < 2)
                        pick.cmd = KIND_CONSUME;
                    else if (!cam_ok)
                    begin
                        pick.cmd       = KIND_CAMERA;
                        pick.camera_up = 1'b1;
                    end
                    else
                        pick.command_code = CMD_INIT;
                end
                default:
                begin
                    if (roll == 3)
                        pick.cmd = KIND_CONSUME;
                    else
                        pick.command_code = CMD_RECOVERY;
                end
            endcase
        end
        return pick;
    endfunction

    task automatic push_item(input item_t it, input logic fixed, input result_t want);
        int      gap;
        result_t predicted;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        cmd              <= it.cmd;
        command_code     <= it.command_code;
        target_id        <= it.target_id;
        target_broadcast <= it.target_broadcast;
        request_tag      <= it.request_tag;
        camera_up        <= it.camera_up;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_controller(it);
        awaited_replies.push_back(fixed ? want : predicted);
    endtask

    task automatic set_node_id(input logic [ID_W-1:0] value);
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        node_id_q = value;
    endtask

    initial
    begin
        item_t           next_item;
        logic [ID_W-1:0] id_val;
        int              n;
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        cmd              = KIND_COMMAND;
        command_code     = CMD_STATUS;
        target_id        = '0;
        target_broadcast = 1'b0;
        request_tag      = '0;
        camera_up        = 1'b0;
        out_ready        = 1'b0;
        node_id_q        = '0;
        ctl_mode         = MODE_STOPPED;
        cam_ok           = 1'b0;
        reset_req        = 1'b0;
        mismatches       = 0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;

        dir_rows = '{
            // reset state, node 0, camera down
            '{'{KIND_COMMAND, CMD_STATUS, 16'h0000, 1'b0, 16'h0000, 1'b0}, 1'b1,
              '{16'h0000, 1'b0, ERR_NONE, 1'b0, MODE_STOPPED, 1'b0, 1'b0}},
            '{'{KIND_COMMAND, CMD_START, 16'h0000, 1'b0, 16'h0001, 1'b0}, 1'b1,
              '{16'h0001, 1'b1, ERR_CAMERA, 1'b0, MODE_STOPPED, 1'b0, 1'b0}},
            '{'{KIND_COMMAND, CMD_START, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1}, 1'b1,
              '{16'hFFFF, 1'b1, ERR_TARGET, 1'b0, MODE_STOPPED, 1'b0, 1'b0}},
            '{'{KIND_COMMAND, CMD_RESTART, 16'hFFFF, 1'b1, 16'h8000, 1'b0}, 1'b1,
              '{16'h8000, 1'b1, ERR_CAMERA, 1'b0, MODE_STOPPED, 1'b0, 1'b0}},
            '{'{KIND_COMMAND, CMD_UNKNOWN, 16'h0000, 1'b0, 16'h7FFF, 1'b0}, 1'b1,
              '{16'h7FFF, 1'b1, ERR_UNSUPPORTED, 1'b0, MODE_STOPPED, 1'b0, 1'b0}},
            '{'{KIND_COMMAND, CMD_CODE_TOP, 16'h0000, 1'b1, 16'h00FF, 1'b0}, 1'b1,
              '{16'h00FF, 1'b1, ERR_UNSUPPORTED, 1'b0, MODE_STOPPED, 1'b0, 1'b0}},
            '{'{KIND_COMMAND, CMD_DEST, 16'h0000, 1'b0, 16'h0100, 1'b0}, 1'b1,
              '{16'h0100, 1'b1, ERR_UNSUPPORTED, 1'b0, MODE_STOPPED, 1'b0, 1'b0}},
            // run, stop, camera loss while running
            '{'{KIND_CAMERA, CMD_CODE_TOP, 16'hFFFF, 1'b1, 16'h0101, 1'b1}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_START, 16'h0000, 1'b0, 16'h0202, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_RESTART, 16'hAAAA, 1'b1, 16'h0303, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_STOP, 16'h0000, 1'b0, 16'h0404, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_STOP, 16'h0000, 1'b0, 16'h0505, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_START, 16'h0000, 1'b1, 16'h0606, 1'b0}, 1'b0, '0},
            '{'{KIND_CAMERA, CMD_STATUS, 16'h5555, 1'b0, 16'h0707, 1'b0}, 1'b0, '0},
            '{'{KIND_CONSUME, CMD_STOP, 16'h0000, 1'b0, 16'h0808, 1'b1}, 1'b0, '0},
            // recovery path
            '{'{KIND_COMMAND, CMD_INIT, 16'h0000, 1'b0, 16'h0909, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_RECOVERY, 16'h0000, 1'b0, 16'h0A0A, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_INIT, 16'h0000, 1'b1, 16'h0B0B, 1'b0}, 1'b0, '0},
            '{'{KIND_CONSUME, CMD_UNKNOWN, 16'hFFFF, 1'b1, 16'h0C0C, 1'b0}, 1'b0, '0},
            '{'{KIND_CAMERA, CMD_START, 16'h0000, 1'b0, 16'h0D0D, 1'b1}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_INIT, 16'h0000, 1'b0, 16'h0E0E, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_ESTOP, 16'h5555, 1'b1, 16'h0F0F, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_START, 16'h0000, 1'b0, 16'h1010, 1'b0}, 1'b0, '0},
            '{'{KIND_COMMAND, CMD_RECOVERY, 16'h0000, 1'b0, 16'h1111, 1'b0}, 1'b0, '0},
            // unused item kind
            '{'{KIND_IGNORED, CMD_CODE_TOP, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1}, 1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_item(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            if (p == 0)
                id_val = '1;
            else if (p == 2)
                id_val = '0;
            else
                id_val = ID_W'($urandom_range(0, 16'hFFFF));
            set_node_id(id_val);
            n = 0;
            while (n < RANDOM_ITEMS / PHASES)
            begin
                if (n % 40 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                next_item = draw_item();
                push_item(next_item, 1'b0, '0);
                if (next_item.cmd != KIND_IGNORED)
                    n++;
            end
        end
        in_valid <= 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
                report_mismatch("result with no item pending, tag", 32'(request_echo), 0);
            else
            begin
                want = awaited_replies.pop_front();
                if (request_echo !== want.request_echo)
                    report_mismatch("request_echo", 32'(request_echo),
                                    32'(want.request_echo));
                if (rejected !== want.rejected)
                    report_mismatch("rejected", 32'(rejected), 32'(want.rejected));
                if (error_kind !== want.error_kind)
                    report_mismatch("error_kind", 32'(error_kind), 32'(want.error_kind));
                if (flush_work !== want.flush_work)
                    report_mismatch("flush_work", 32'(flush_work), 32'(want.flush_work));
                if (mode_now !== want.mode_now)
                    report_mismatch("mode_now", 32'(mode_now), 32'(want.mode_now));
                if (processing_on !== want.processing_on)
                    report_mismatch("processing_on", 32'(processing_on),
                                    32'(want.processing_on));
                if (reset_was_pending !== want.reset_was_pending)
                    report_mismatch("reset_was_pending", 32'(reset_was_pending),
                                    32'(want.reset_was_pending));
            end
        end
    end

    // no-progress watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
